### design/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

    localparam logic [31:0] MAGIC_WORD       = 32'h4E535443;
    localparam logic [31:0] VERSION_WORD     = 32'd1;
    localparam logic [31:0] CRC_POLY         = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [5:0]  PORTABLE_MIN_LEN = 6'd29;
    localparam logic [5:0]  NATIVE_MIN_LEN   = 6'd37;

    localparam logic [3:0] PH_MAGIC      = 4'd0;
    localparam logic [3:0] PH_VERSION    = 4'd1;
    localparam logic [3:0] PH_FORMAT     = 4'd2;
    localparam logic [3:0] PH_SLOT       = 4'd3;
    localparam logic [3:0] PH_COUNT      = 4'd4;
    localparam logic [3:0] PH_FRAME_CNT  = 4'd5;
    localparam logic [3:0] PH_KEY_LEN    = 4'd6;
    localparam logic [3:0] PH_KEY        = 4'd7;
    localparam logic [3:0] PH_CELL_SLOT  = 4'd8;
    localparam logic [3:0] PH_TOMBSTONE  = 4'd9;
    localparam logic [3:0] PH_VALUE_LEN  = 4'd10;
    localparam logic [3:0] PH_VALUE      = 4'd11;
    localparam logic [3:0] PH_PAGE_ID    = 4'd12;
    localparam logic [3:0] PH_FRAME_LEN  = 4'd13;
    localparam logic [3:0] PH_FRAME      = 4'd14;
    localparam logic [3:0] PH_NONE       = 4'd15;

    localparam logic [4:0] ROLE_STATUS   = 5'd16;

    localparam logic [1:0] FMT_UNKNOWN   = 2'd0;
    localparam logic [1:0] FMT_PORTABLE  = 2'd1;
    localparam logic [1:0] FMT_NATIVE    = 2'd2;

    localparam logic [1:0] HF_MAGIC      = 2'b01;
    localparam logic [1:0] HF_VERSION    = 2'b10;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_MAGIC      = 4'd2;
    localparam logic [3:0] ST_VERSION    = 4'd3;
    localparam logic [3:0] ST_FORMAT     = 4'd4;
    localparam logic [3:0] ST_CRC        = 4'd5;
    localparam logic [3:0] ST_TR_KEY_LEN = 4'd6;
    localparam logic [3:0] ST_TR_KEY     = 4'd7;
    localparam logic [3:0] ST_TR_CELL    = 4'd8;
    localparam logic [3:0] ST_TR_VALUE   = 4'd9;
    localparam logic [3:0] ST_TR_FR_HDR  = 4'd10;
    localparam logic [3:0] ST_TR_FRAME   = 4'd11;
    localparam logic [3:0] ST_TRAILING   = 4'd12;

    localparam logic CFG_PORTABLE = 1'b0;
    localparam logic CFG_NATIVE   = 1'b1;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [4:0]  role;
        logic [7:0]  byte_value;
        logic        field_done;
        logic [63:0] field_value;
        logic [63:0] record_index;
        logic [3:0]  status;
        logic        last_result;
    } result_t;

    function automatic logic [3:0] fixed_width(input logic [3:0] ph);
        logic [3:0] w;
        case (ph)
            PH_MAGIC:     w = 4'd4;
            PH_VERSION:   w = 4'd4;
            PH_FORMAT:    w = 4'd1;
            PH_SLOT:      w = 4'd8;
            PH_COUNT:     w = 4'd8;
            PH_FRAME_CNT: w = 4'd8;
            PH_KEY_LEN:   w = 4'd4;
            PH_CELL_SLOT: w = 4'd8;
            PH_TOMBSTONE: w = 4'd1;
            PH_VALUE_LEN: w = 4'd4;
            PH_PAGE_ID:   w = 4'd8;
            PH_FRAME_LEN: w = 4'd4;
            default:      w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/snapshot_stream_deframer.sv
// A result enters the output queue registers when its causing byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the CRC and parse update
// are one pass of logic. An end-marked byte that also releases a body byte gives
// two results, which leave the four-entry output queue one at a time; input stalls
// while fewer than two queue entries are free.
// Reset (rst_n low, asynchronous) clears the stream state, the queue and restores
// the format codes to portable 0 and native 1.
`default_nettype none

module snapshot_stream_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        stream_end,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       role,
    output logic [7:0]       byte_value,
    output logic             field_done,
    output logic [63:0]      field_value,
    output logic [63:0]      record_index,
    output logic [3:0]       status,
    output logic             last_result
);

    logic [7:0]  portable_code_reg;
    logic [7:0]  native_code_reg;

    logic [7:0]  hold_reg [4];
    logic [7:0]  hold_next [4];
    logic [2:0]  hold_count_reg, hold_count_next;
    logic [5:0]  length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  fbi_reg, fbi_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [63:0] expected_reg, expected_next;
    logic [63:0] done_reg, done_next;
    logic [1:0]  format_reg, format_next;
    logic [1:0]  hfault_reg, hfault_next;
    logic [3:0]  pfault_reg, pfault_next;

    ssd_pkg::result_t fifo_reg [ssd_pkg::FIFO_DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;

    ssd_pkg::result_t res0, res1;
    logic [1:0]  n_res;
    logic        in_take, out_take;

    logic [7:0]  rel;
    logic [3:0]  width;
    logic [63:0] acc_new;
    logic [31:0] left_dec;
    logic [63:0] done_inc;
    logic        rec_end;
    logic [1:0]  fmt_new;
    logic [31:0] want;
    logic [3:0]  st;
    ssd_pkg::result_t body;
    ssd_pkg::result_t stat;

    assign in_stall  = count_reg[2] | (&count_reg[1:0]);
    assign out_valid = (count_reg != 3'd0);
    assign in_take   = in_valid & ~in_stall;
    assign out_take  = out_valid & ~out_stall;

    assign role         = fifo_reg[rd_ptr_reg].role;
    assign byte_value   = fifo_reg[rd_ptr_reg].byte_value;
    assign field_done   = fifo_reg[rd_ptr_reg].field_done;
    assign field_value  = fifo_reg[rd_ptr_reg].field_value;
    assign record_index = fifo_reg[rd_ptr_reg].record_index;
    assign status       = fifo_reg[rd_ptr_reg].status;
    assign last_result  = fifo_reg[rd_ptr_reg].last_result;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            hold_next[i] = hold_reg[i];
        end
        hold_count_next = hold_count_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        phase_next      = phase_reg;
        fbi_next        = fbi_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        expected_next   = expected_reg;
        done_next       = done_reg;
        format_next     = format_reg;
        hfault_next     = hfault_reg;
        pfault_next     = pfault_reg;

        rel      = hold_reg[0];
        width    = ssd_pkg::fixed_width(phase_reg);
        acc_new  = acc_reg | ({56'd0, rel} << {fbi_reg, 3'b000});
        left_dec = (left_reg != 32'd0) ? (left_reg - 32'd1) : left_reg;
        done_inc = done_reg + 64'd1;
        rec_end  = 1'b0;
        fmt_new  = ssd_pkg::FMT_UNKNOWN;
        want     = 32'd0;
        st       = ssd_pkg::ST_OK;
        body     = '0;
        stat     = '0;
        res0     = '0;
        res1     = '0;
        n_res    = 2'd0;

        if (in_take)
        begin
            if (length_reg < ssd_pkg::NATIVE_MIN_LEN)
            begin
                length_next = length_reg + 6'd1;
            end

            if (hold_count_reg[2])
            begin
                hold_next[0] = hold_reg[1];
                hold_next[1] = hold_reg[2];
                hold_next[2] = hold_reg[3];
                hold_next[3] = data_byte;

                crc_next          = ssd_pkg::crc_byte(crc_reg, rel);
                body.role         = {1'b0, phase_reg};
                body.byte_value   = rel;
                body.record_index = done_reg;

                if (phase_reg == ssd_pkg::PH_NONE)
                begin
                    pfault_next = ssd_pkg::ST_TRAILING;
                end
                else if (width == 4'd0)
                begin
                    left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        if (phase_reg == ssd_pkg::PH_KEY)
                        begin
                            phase_next = ssd_pkg::PH_CELL_SLOT;
                        end
                        else
                        begin
                            rec_end = 1'b1;
                        end
                    end
                end
                else if (({1'b0, fbi_reg} + 4'd1) < width)
                begin
                    fbi_next = fbi_reg + 3'd1;
                    acc_next = acc_new;
                end
                else
                begin
                    fbi_next        = 3'd0;
                    acc_next        = 64'd0;
                    body.field_done = 1'b1;
                    if (phase_reg == ssd_pkg::PH_TOMBSTONE)
                    begin
                        body.field_value = {63'd0, |acc_new};
                    end
                    else
                    begin
                        body.field_value = acc_new;
                    end

                    case (phase_reg)
                        ssd_pkg::PH_MAGIC:
                        begin
                            if (acc_new[31:0] != ssd_pkg::MAGIC_WORD)
                            begin
                                hfault_next = hfault_reg | ssd_pkg::HF_MAGIC;
                            end
                            phase_next = ssd_pkg::PH_VERSION;
                        end
                        ssd_pkg::PH_VERSION:
                        begin
                            if (acc_new[31:0] != ssd_pkg::VERSION_WORD)
                            begin
                                hfault_next = hfault_reg | ssd_pkg::HF_VERSION;
                            end
                            phase_next = ssd_pkg::PH_FORMAT;
                        end
                        ssd_pkg::PH_FORMAT:
                        begin
                            if (acc_new[7:0] == native_code_reg)
                            begin
                                fmt_new = ssd_pkg::FMT_NATIVE;
                            end
                            else if (acc_new[7:0] == portable_code_reg)
                            begin
                                fmt_new = ssd_pkg::FMT_PORTABLE;
                            end
                            format_next = fmt_new;
                            if (hfault_reg != 2'd0 || fmt_new == ssd_pkg::FMT_UNKNOWN)
                            begin
                                phase_next = ssd_pkg::PH_NONE;
                            end
                            else
                            begin
                                phase_next = ssd_pkg::PH_SLOT;
                            end
                        end
                        ssd_pkg::PH_SLOT:
                        begin
                            phase_next = ssd_pkg::PH_COUNT;
                        end
                        ssd_pkg::PH_COUNT:
                        begin
                            if (format_reg == ssd_pkg::FMT_NATIVE)
                            begin
                                phase_next = ssd_pkg::PH_FRAME_CNT;
                            end
                            else
                            begin
                                expected_next = acc_new;
                                phase_next    = (acc_new == 64'd0) ? ssd_pkg::PH_NONE
                                                                   : ssd_pkg::PH_KEY_LEN;
                            end
                        end
                        ssd_pkg::PH_FRAME_CNT:
                        begin
                            expected_next = acc_new;
                            phase_next    = (acc_new == 64'd0) ? ssd_pkg::PH_NONE
                                                               : ssd_pkg::PH_PAGE_ID;
                        end
                        ssd_pkg::PH_KEY_LEN:
                        begin
                            left_next  = acc_new[31:0];
                            phase_next = (acc_new[31:0] == 32'd0) ? ssd_pkg::PH_CELL_SLOT
                                                                  : ssd_pkg::PH_KEY;
                        end
                        ssd_pkg::PH_CELL_SLOT:
                        begin
                            phase_next = ssd_pkg::PH_TOMBSTONE;
                        end
                        ssd_pkg::PH_TOMBSTONE:
                        begin
                            phase_next = ssd_pkg::PH_VALUE_LEN;
                        end
                        ssd_pkg::PH_VALUE_LEN:
                        begin
                            left_next = acc_new[31:0];
                            if (acc_new[31:0] == 32'd0)
                            begin
                                rec_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = ssd_pkg::PH_VALUE;
                            end
                        end
                        ssd_pkg::PH_PAGE_ID:
                        begin
                            phase_next = ssd_pkg::PH_FRAME_LEN;
                        end
                        ssd_pkg::PH_FRAME_LEN:
                        begin
                            left_next = acc_new[31:0];
                            if (acc_new[31:0] == 32'd0)
                            begin
                                rec_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = ssd_pkg::PH_FRAME;
                            end
                        end
                        default:
                        begin
                            phase_next = ssd_pkg::PH_NONE;
                        end
                    endcase
                end

                if (rec_end)
                begin
                    done_next = done_inc;
                    if (done_inc == expected_reg)
                    begin
                        phase_next = ssd_pkg::PH_NONE;
                    end
                    else if (format_reg == ssd_pkg::FMT_NATIVE)
                    begin
                        phase_next = ssd_pkg::PH_PAGE_ID;
                    end
                    else
                    begin
                        phase_next = ssd_pkg::PH_KEY_LEN;
                    end
                end

                res0  = body;
                n_res = 2'd1;
            end
            else
            begin
                hold_next[hold_count_reg[1:0]] = data_byte;
                hold_count_next = hold_count_reg + 3'd1;
            end

            if (stream_end)
            begin
                want = {hold_next[3], hold_next[2], hold_next[1], hold_next[0]};
                if (length_next < ssd_pkg::PORTABLE_MIN_LEN)
                begin
                    st = ssd_pkg::ST_SHORT;
                end
                else if (hfault_next[0])
                begin
                    st = ssd_pkg::ST_MAGIC;
                end
                else if (hfault_next[1])
                begin
                    st = ssd_pkg::ST_VERSION;
                end
                else if (format_next == ssd_pkg::FMT_UNKNOWN)
                begin
                    st = ssd_pkg::ST_FORMAT;
                end
                else if (format_next == ssd_pkg::FMT_NATIVE
                         && length_next < ssd_pkg::NATIVE_MIN_LEN)
                begin
                    st = ssd_pkg::ST_SHORT;
                end
                else if (~crc_next != want)
                begin
                    st = ssd_pkg::ST_CRC;
                end
                else
                begin
                    case (phase_next)
                        ssd_pkg::PH_KEY_LEN:   st = ssd_pkg::ST_TR_KEY_LEN;
                        ssd_pkg::PH_KEY:       st = ssd_pkg::ST_TR_KEY;
                        ssd_pkg::PH_CELL_SLOT: st = ssd_pkg::ST_TR_CELL;
                        ssd_pkg::PH_TOMBSTONE: st = ssd_pkg::ST_TR_CELL;
                        ssd_pkg::PH_VALUE_LEN: st = ssd_pkg::ST_TR_CELL;
                        ssd_pkg::PH_VALUE:     st = ssd_pkg::ST_TR_VALUE;
                        ssd_pkg::PH_PAGE_ID:   st = ssd_pkg::ST_TR_FR_HDR;
                        ssd_pkg::PH_FRAME_LEN: st = ssd_pkg::ST_TR_FR_HDR;
                        ssd_pkg::PH_FRAME:     st = ssd_pkg::ST_TR_FRAME;
                        ssd_pkg::PH_NONE:      st = (pfault_next != ssd_pkg::ST_OK)
                                                    ? ssd_pkg::ST_TRAILING : ssd_pkg::ST_OK;
                        default:               st = ssd_pkg::ST_SHORT;
                    endcase
                end

                stat.role        = ssd_pkg::ROLE_STATUS;
                stat.status      = st;
                stat.last_result = 1'b1;
                if (hold_count_reg[2])
                begin
                    res1  = stat;
                    n_res = 2'd2;
                end
                else
                begin
                    res0  = stat;
                    n_res = 2'd1;
                end

                for (int i = 0; i < 4; i++)
                begin
                    hold_next[i] = 8'd0;
                end
                hold_count_next = 3'd0;
                length_next     = 6'd0;
                crc_next        = ssd_pkg::CRC_INIT;
                phase_next      = ssd_pkg::PH_MAGIC;
                fbi_next        = 3'd0;
                acc_next        = 64'd0;
                left_next       = 32'd0;
                expected_next   = 64'd0;
                done_next       = 64'd0;
                format_next     = ssd_pkg::FMT_UNKNOWN;
                hfault_next     = 2'd0;
                pfault_next     = ssd_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_res;
        rd_ptr_next = rd_ptr_reg + {1'b0, out_take};
        count_next  = count_reg + {1'b0, n_res} - {2'b00, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portable_code_reg <= 8'd0;
            native_code_reg   <= 8'd1;
            for (int i = 0; i < 4; i++)
            begin
                hold_reg[i] <= 8'd0;
            end
            hold_count_reg <= 3'd0;
            length_reg     <= 6'd0;
            crc_reg        <= ssd_pkg::CRC_INIT;
            phase_reg      <= ssd_pkg::PH_MAGIC;
            fbi_reg        <= 3'd0;
            acc_reg        <= 64'd0;
            left_reg       <= 32'd0;
            expected_reg   <= 64'd0;
            done_reg       <= 64'd0;
            format_reg     <= ssd_pkg::FMT_UNKNOWN;
            hfault_reg     <= 2'd0;
            pfault_reg     <= ssd_pkg::ST_OK;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            count_reg      <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == ssd_pkg::CFG_PORTABLE)
                begin
                    portable_code_reg <= cfg_data;
                end
                if (cfg_index == ssd_pkg::CFG_NATIVE)
                begin
                    native_code_reg <= cfg_data;
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                hold_reg[i] <= hold_next[i];
            end
            hold_count_reg <= hold_count_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            phase_reg      <= phase_next;
            fbi_reg        <= fbi_next;
            acc_reg        <= acc_next;
            left_reg       <= left_next;
            expected_reg   <= expected_next;
            done_reg       <= done_next;
            format_reg     <= format_next;
            hfault_reg     <= hfault_next;
            pfault_reg     <= pfault_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

`default_nettype wire
